>>> rtl/integer_to_roman_numeral_top_assert.svh
// Assertion macros for the Roman numeral converter checker.
// Used by itr_checker.sv; expects signals clk and rst_n in scope.
`ifndef INTEGER_TO_ROMAN_NUMERAL_TOP_ASSERT_SVH
`define INTEGER_TO_ROMAN_NUMERAL_TOP_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define ITR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define ITR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checked also while reset is asserted.
`define ITR_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/itr_pkg.sv
// Package for the integer to Roman numeral converter: types, letter codes
// and the digit pattern functions. No dependencies.
`timescale 1ns / 1ps

package itr_pkg;

  localparam int VALUE_W   = 12;
  localparam int CHAR_W    = 7;
  localparam int REM1_W    = 10;  // remainder below 1000
  localparam int REM2_W    = 7;   // remainder below 100
  localparam int QDEPTH    = 2;
  localparam int QADDR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

  localparam logic [CHAR_W-1:0] CH_M = 7'h4D;
  localparam logic [CHAR_W-1:0] CH_D = 7'h44;
  localparam logic [CHAR_W-1:0] CH_C = 7'h43;
  localparam logic [CHAR_W-1:0] CH_L = 7'h4C;
  localparam logic [CHAR_W-1:0] CH_X = 7'h58;
  localparam logic [CHAR_W-1:0] CH_V = 7'h56;
  localparam logic [CHAR_W-1:0] CH_I = 7'h49;

  // Decade positions, most significant first.
  localparam logic [1:0] DEC_THOUSANDS = 2'd0;
  localparam logic [1:0] DEC_HUNDREDS  = 2'd1;
  localparam logic [1:0] DEC_TENS      = 2'd2;
  localparam logic [1:0] DEC_ONES      = 2'd3;

  typedef logic [3:0] digit_t;
  typedef digit_t [3:0] digits_t;  // index is the decade position

  typedef enum logic [1:0] {
    SEL_UNIT,
    SEL_FIVE,
    SEL_TEN
  } sel_t;

  // Number of letters that one decimal digit produces.
  function automatic logic [2:0] digit_len(input digit_t d);
    logic [2:0] len;
    case (d) inside
      4'd1, 4'd5:       len = 3'd1;
      4'd2, 4'd4, 4'd9: len = 3'd2;
      4'd3, 4'd7:       len = 3'd3;
      4'd6:             len = 3'd2;
      4'd8:             len = 3'd4;
      default:          len = 3'd0;
    endcase
    return len;
  endfunction

  // Which decade letter stands at position k of a digit's pattern.
  function automatic sel_t letter_sel(input digit_t d, input logic [1:0] k);
    sel_t s;
    case (d)
      4'd4:    s = (k == 2'd0) ? SEL_UNIT : SEL_FIVE;
      4'd5:    s = SEL_FIVE;
      4'd6, 4'd7, 4'd8: s = (k == 2'd0) ? SEL_FIVE : SEL_UNIT;
      4'd9:    s = (k == 2'd0) ? SEL_UNIT : SEL_TEN;
      default: s = SEL_UNIT;
    endcase
    return s;
  endfunction

  function automatic logic [CHAR_W-1:0] letter(input logic [1:0] dec, input sel_t s);
    logic [CHAR_W-1:0] c;
    case (dec)
      DEC_HUNDREDS: c = (s == SEL_UNIT) ? CH_C : (s == SEL_FIVE) ? CH_D : CH_M;
      DEC_TENS:     c = (s == SEL_UNIT) ? CH_X : (s == SEL_FIVE) ? CH_L : CH_C;
      DEC_ONES:     c = (s == SEL_UNIT) ? CH_I : (s == SEL_FIVE) ? CH_V : CH_X;
      default:      c = CH_M;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/itr_if.sv
// Handshake channel interfaces for the Roman numeral converter.
// Depends on itr_pkg for the payload widths.
`timescale 1ns / 1ps

interface itr_in_if
  import itr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itr_out_if
  import itr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> rtl/integer_to_roman_numeral_top.sv
// Integer to Roman numeral converter, top level.
// The in_ch channel takes one 12-bit value per item; values above 3999 are
// converted as 3999, and zero produces no letters. The out_ch channel gives
// the numeral as ASCII letters, most significant first, one item per letter,
// with last set on the final letter of each numeral (1 to 15 letters).
// After a value is accepted, its first letter passes through three digit-split
// stages, the queue and the letter walker before it shows on out_ch.
// The back end emits one letter per cycle while out_ch.ready stays high; the
// letter walker has a single output register. When the queue holds the next
// value, the walker takes it while emitting the last letter of the current
// numeral. The front end keeps accepting values while the back end is busy,
// until its stages and the two-entry queue fill.
// If the receiver holds out_ch.ready low, the current letter stays on the
// port and the queue backs up into in_ch.ready.
// Reset (rst_n low at a clock edge) empties the pipeline, the queue and the
// output register; no letter is shown until a new value arrives.
`timescale 1ns / 1ps

module integer_to_roman_numeral_top
  import itr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  itr_in_if.sink     in_ch,
  itr_out_if.source  out_ch
);

  logic    push, q_full, q_valid, pop;
  digits_t push_digits, q_data;

  itr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_value    (in_ch.value),
    .push        (push),
    .push_digits (push_digits),
    .q_full      (q_full)
  );

  itr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_digits),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop)
  );

  itr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_char_code (out_ch.char_code),
    .out_last      (out_ch.last)
  );

endmodule

>>> rtl/itr_front.sv
// Front end: accepts values, saturates them and splits them into decimal
// digits over three pipeline stages. Depends on itr_pkg.
`timescale 1ns / 1ps

module itr_front
  import itr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               push,
  output digits_t            push_digits,
  input  logic               q_full
);

  logic               s1_valid_r, s2_valid_r, s3_valid_r;
  logic [VALUE_W-1:0] s1_value_r;
  digit_t             s2_thou_r;
  logic [REM1_W-1:0]  s2_rem_r;
  digit_t             s3_thou_r, s3_hund_r;
  logic [REM2_W-1:0]  s3_rem_r;

  logic adv1, adv2, adv3;

  // Stage results.
  digit_t             thou;
  logic [REM1_W-1:0]  rem1;
  digit_t             hund;
  logic [REM2_W-1:0]  rem2;
  digit_t             tens;
  digit_t             ones;

  assign adv3     = s3_valid_r && !q_full;
  assign adv2     = s2_valid_r && (!s3_valid_r || adv3);
  assign adv1     = s1_valid_r && (!s2_valid_r || adv2);
  assign in_ready = !s1_valid_r || adv1;

  always_comb begin
    if (s1_value_r >= 12'd3000) begin
      thou = 4'd3;
      rem1 = REM1_W'(s1_value_r - 12'd3000);
    end else if (s1_value_r >= 12'd2000) begin
      thou = 4'd2;
      rem1 = REM1_W'(s1_value_r - 12'd2000);
    end else if (s1_value_r >= 12'd1000) begin
      thou = 4'd1;
      rem1 = REM1_W'(s1_value_r - 12'd1000);
    end else begin
      thou = 4'd0;
      rem1 = REM1_W'(s1_value_r);
    end
  end

  always_comb begin
    hund = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (s2_rem_r >= REM1_W'(i * 100)) hund = 4'(i);
    end
    rem2 = REM2_W'(s2_rem_r - (REM1_W'(hund) * 10'd100));
  end

  always_comb begin
    tens = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (s3_rem_r >= REM2_W'(i * 10)) tens = 4'(i);
    end
    ones = 4'(s3_rem_r - (REM2_W'(tens) * 7'd10));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (!s2_valid_r || adv2) s2_valid_r <= adv1;
      if (!s3_valid_r || adv3) s3_valid_r <= adv2;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_value_r <= (in_value > VALUE_MAX) ? VALUE_MAX : in_value;
    end
    if (adv1) begin
      s2_thou_r <= thou;
      s2_rem_r  <= rem1;
    end
    if (adv2) begin
      s3_thou_r <= s2_thou_r;
      s3_hund_r <= hund;
      s3_rem_r  <= rem2;
    end
  end

  assign push = adv3;
  always_comb begin
    push_digits                = '0;
    push_digits[DEC_THOUSANDS] = s3_thou_r;
    push_digits[DEC_HUNDREDS]  = s3_hund_r;
    push_digits[DEC_TENS]      = tens;
    push_digits[DEC_ONES]      = ones;
  end

endmodule

>>> rtl/itr_queue.sv
// Short FIFO of digit sets between the front and back ends.
// Depends on itr_pkg.
`timescale 1ns / 1ps

module itr_queue
  import itr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  digits_t push_data,
  output logic    full,
  output logic    q_valid,
  output digits_t q_data,
  input  logic    pop
);

  digits_t            mem [QDEPTH];
  logic [QADDR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem[rd_ptr_r];

  function automatic logic [QADDR_W-1:0] ptr_inc(input logic [QADDR_W-1:0] p);
    return (p == QADDR_W'(QDEPTH - 1)) ? '0 : QADDR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

endmodule

>>> rtl/itr_back.sv
// Back end: walks the digits of a queued value; while out_ready allows,
// emits a letter per cycle to a registered output. Depends on itr_pkg.
`timescale 1ns / 1ps

module itr_back
  import itr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  digits_t           q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_last
);

  logic              act_r;
  digits_t           digits_r;
  logic [1:0]        dec_r;
  logic [1:0]        k_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic       emit, take, more_here, found_next, has_next;
  logic [1:0] next_dec;
  logic       found_first;
  logic [1:0] first_dec;
  digit_t     cur_d;

  assign cur_d     = digits_r[dec_r];
  assign more_here = ((3'(k_r) + 3'd1) < digit_len(cur_d));

  // Next decade that has letters, after the current one.
  always_comb begin
    found_next = 1'b0;
    next_dec   = dec_r;
    for (int j = 0; j < 4; j++) begin
      if ((2'(j) > dec_r) && (digits_r[2'(j)] != '0) && !found_next) begin
        found_next = 1'b1;
        next_dec   = 2'(j);
      end
    end
  end

  // First decade with letters in the queued item; a zero value has none.
  always_comb begin
    found_first = 1'b0;
    first_dec   = DEC_THOUSANDS;
    for (int j = 0; j < 4; j++) begin
      if ((q_data[2'(j)] != '0) && !found_first) begin
        found_first = 1'b1;
        first_dec   = 2'(j);
      end
    end
  end

  assign has_next = more_here || found_next;
  assign emit     = act_r && (!out_valid_r || out_ready);
  assign take     = q_valid && (!act_r || (emit && !has_next));
  assign pop      = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take)                act_r <= found_first;
      else if (emit && !has_next) act_r <= 1'b0;

      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      digits_r <= q_data;
      dec_r    <= first_dec;
      k_r      <= 2'd0;
    end else if (emit && has_next) begin
      if (more_here) begin
        k_r <= k_r + 2'd1;
      end else begin
        dec_r <= next_dec;
        k_r   <= 2'd0;
      end
    end
    if (emit) begin
      out_char_r <= letter(dec_r, letter_sel(cur_d, k_r));
      out_last_r <= !has_next;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

>>> rtl/itr_checker.sv
// Port-level checker for the Roman numeral converter, bound to the top level.
// Depends on itr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "integer_to_roman_numeral_top_assert.svh"

module itr_checker
  import itr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char_code,
  input logic              out_last
);

  `ITR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output item dropped while stalled")
  `ITR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_char_code) && $stable(out_last), "stalled output item changed")
  `ITR_ASSERT_NOW(a_letter, out_valid, (out_char_code == CH_M) || (out_char_code == CH_D) || (out_char_code == CH_C) || (out_char_code == CH_L) || (out_char_code == CH_X) || (out_char_code == CH_V) || (out_char_code == CH_I), "output is not a numeral letter")
  `ITR_ASSERT_ALWAYS_NEXT(a_reset_clear, !rst_n, !out_valid, "output valid after reset")

endmodule

bind integer_to_roman_numeral_top itr_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_char_code (out_ch.char_code),
  .out_last      (out_ch.last)
);

>>> test/testbench.sv
// Testbench for integer_to_roman_numeral_top: random and directed values go in, and
// a scoreboard predicts each numeral and checks every letter that comes out.
// Depends on itr_pkg and the channel interfaces in itr_if.sv.
`timescale 1ns / 1ps

module testbench;
  import itr_pkg::*;

  localparam int RANDOM_ITEMS = 125;
  localparam int MAX_GAP      = 18;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } letter_t;

  // Predicts numerals for accepted values and checks the letters in order.
  class numeral_scoreboard;
    letter_t pending[$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    // Append the letters of one decimal digit of a lower decade.
    function void add_digit(input int digit, input logic [CHAR_W-1:0] unit_ch,
                            input logic [CHAR_W-1:0] five_ch,
                            input logic [CHAR_W-1:0] ten_ch,
                            ref logic [CHAR_W-1:0] word[$]);
      if (digit >= 1 && digit <= 3) begin
        repeat (digit) word.push_back(unit_ch);
      end else if (digit == 4) begin
        word.push_back(unit_ch);
        word.push_back(five_ch);
      end else if (digit >= 5 && digit <= 8) begin
        word.push_back(five_ch);
        repeat (digit - 5) word.push_back(unit_ch);
      end else if (digit == 9) begin
        word.push_back(unit_ch);
        word.push_back(ten_ch);
      end
    endfunction

    function void note_value(input logic [VALUE_W-1:0] raw);
      int               v;
      logic [CHAR_W-1:0] word[$];
      letter_t          l;
      v = raw;
      if (v > VALUE_MAX) v = VALUE_MAX;
      repeat (v / 1000) word.push_back(CH_M);
      add_digit((v % 1000) / 100, CH_C, CH_D, CH_M, word);
      add_digit((v % 100) / 10, CH_X, CH_L, CH_C, word);
      add_digit(v % 10, CH_I, CH_V, CH_X, word);
      foreach (word[i]) begin
        l.char_code = word[i];
        l.last      = (i == word.size() - 1);
        pending.push_back(l);
      end
    endfunction

    function void check_letter(input logic [CHAR_W-1:0] char_code, input logic last);
      letter_t exp_l;
      if (pending.size() == 0) begin
        $error("unexpected letter: char_code=%h last=%b", char_code, last);
        errors++;
        return;
      end
      exp_l = pending.pop_front();
      if (char_code !== exp_l.char_code) begin
        $error("char_code: expected %h, actual %h", exp_l.char_code, char_code);
        errors++;
      end
      if (last !== exp_l.last) begin
        $error("last: expected %b, actual %b", exp_l.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   in_mode;
  int   out_mode;

  itr_in_if  in_if ();
  itr_out_if out_if ();

  integer_to_roman_numeral_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  numeral_scoreboard numerals = new();

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Both channels are sampled at the edge, before any update of that step lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) numerals.note_value(in_if.value);
      if (out_if.valid && out_if.ready)
        numerals.check_letter(out_if.char_code, out_if.last);
    end
  end

  // Mode 0 never idles, mode 1 idles up to the maximum, mode 2 idles now and then.
  function automatic int draw_gap(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, MAX_GAP);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick <= 2) return VALUE_W'($urandom_range(4000, 4095));
    if (pick <= 4) return VALUE_W'($urandom_range(0, 4095));
    return VALUE_W'($urandom_range(1, 3999));
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = draw_gap(in_mode);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Receiver: stalls a drawn number of cycles before taking each letter.
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(out_mode);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  initial begin
    logic [VALUE_W-1:0] directed[$];
    int                 wait_cycles;
    directed = '{12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd0, 12'd3888, 12'd4,
                 12'd5, 12'd8, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900,
                 12'd444, 12'd999, 12'd1994, 12'd2024, 12'd1365, 12'd2730,
                 12'd2048, 12'd1000, 12'd3000, 12'd49, 12'd0};
    in_mode      = 0;
    out_mode     = 0;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.value  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (i % 8 == 0) begin
        in_mode  = $urandom_range(0, 2);
        out_mode = $urandom_range(0, 2);
      end
      send_value(directed[i]);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Change the idling pattern every 20 items, so bursts and stalls both occur.
      if (n % 20 == 0) begin
        in_mode  = $urandom_range(0, 2);
        out_mode = $urandom_range(0, 2);
      end
      send_value(random_value());
    end
    in_if.valid <= 1'b0;

    while (numerals.pending.size() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < DRAIN_CYCLES) begin
      @(posedge clk);
      wait_cycles++;
    end

    if (numerals.errors == 0 && numerals.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
